### sv/wps_pkg.sv
package wps_pkg;

    // Table geometry and field widths.
    localparam int MAX_ENTRIES = 65536;
    localparam int WEIGHT_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int SUM_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int WIDTH_W     = 13;
    localparam int STEP_W      = $clog2(ADDR_W);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(256);
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(MAX_ENTRIES);
    localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(ADDR_W - 1);

    // Action codes carried by an input word.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic restart;
        logic query_start;
        logic search_rd;
        logic search_cmp;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_more;
        logic div_last;
    } status_t;

endpackage

### sv/weighted_pixel_sampler.sv
// Weighted pixel sampler. Load words (action 0) append one weight to a table
// of running sums; restart words (action 2) empty the table; action 3 is
// dropped. Neither load nor restart gives a result. A query word (action 1)
// scales the total by the fraction, binary-searches the table, and returns
// one result word with the chosen index, its column and row for the
// configured image width, and a found flag (all fields zero on a miss). The
// sum table has a single read port, so each search step is a read state
// followed by a compare state; the divider yields one quotient bit per cycle.
// The block works on one query at a time and takes no word while a query
// runs; loads and restarts are taken while a result waits on the output.
// The image width may be written only while the block is idle.
module weighted_pixel_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_weight,
    input  logic [15:0] s_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_entry_index,
    output logic [11:0] m_pixel_x,
    output logic [15:0] m_pixel_y
);

    wps_pkg::cmd_t    cmd;
    wps_pkg::status_t status;

    // Sequencer.
    wps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, search and divider.
    wps_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_weight      (s_weight),
        .s_fraction    (s_fraction),
        .cmd           (cmd),
        .status        (status),
        .m_found       (m_found),
        .m_entry_index (m_entry_index),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y)
    );

endmodule

### sv/wps_ctrl.sv
module wps_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_action,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  wps_pkg::status_t status,
    output wps_pkg::cmd_t    cmd
);

    wps_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    // The result slot can take a new word when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wps_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wps_pkg::ST_IDLE: begin
                if (s_valid && s_action == wps_pkg::ACT_QUERY) begin
                    state_next = wps_pkg::ST_SEARCH_RD;
                end
            end
            wps_pkg::ST_SEARCH_RD: begin
                if (status.search_more) begin
                    state_next = wps_pkg::ST_SEARCH_CMP;
                end else begin
                    state_next = wps_pkg::ST_DIV;
                end
            end
            wps_pkg::ST_SEARCH_CMP: begin
                state_next = wps_pkg::ST_SEARCH_RD;
            end
            wps_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = wps_pkg::ST_DONE;
                end
            end
            wps_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wps_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            wps_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_action)
                        wps_pkg::ACT_LOAD:    cmd.load        = 1'b1;
                        wps_pkg::ACT_QUERY:   cmd.query_start = 1'b1;
                        wps_pkg::ACT_RESTART: cmd.restart     = 1'b1;
                        default: begin
                        end
                    endcase
                end
            end
            wps_pkg::ST_SEARCH_RD: begin
                if (status.search_more) begin
                    cmd.search_rd = 1'b1;
                end else begin
                    cmd.div_init = 1'b1;
                end
            end
            wps_pkg::ST_SEARCH_CMP: begin
                cmd.search_cmp = 1'b1;
            end
            wps_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            wps_pkg::ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Result valid: set when a result is loaded, cleared when taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### sv/wps_datapath.sv
module wps_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wps_pkg::WIDTH_W-1:0]     cfg_wr_data,
    input  logic [15:0]                     s_weight,
    input  logic [15:0]                     s_fraction,
    input  wps_pkg::cmd_t                   cmd,
    output wps_pkg::status_t                status,
    output logic                            m_found,
    output logic [15:0]                     m_entry_index,
    output logic [11:0]                     m_pixel_x,
    output logic [15:0]                     m_pixel_y
);

    localparam int ADDR_W  = wps_pkg::ADDR_W;
    localparam int COUNT_W = wps_pkg::COUNT_W;
    localparam int SUM_W   = wps_pkg::SUM_W;
    localparam int FRAC_W  = wps_pkg::FRAC_W;
    localparam int WIDTH_W = wps_pkg::WIDTH_W;
    localparam int STEP_W  = wps_pkg::STEP_W;
    localparam int PROD_W  = SUM_W + FRAC_W;

    // Running-sum table, written by loads and read by the search.
    logic [SUM_W-1:0] cum_mem [wps_pkg::MAX_ENTRIES];
    logic [SUM_W-1:0] rd_data_reg;

    logic [WIDTH_W-1:0] width_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [SUM_W-1:0]   scaled_reg;
    logic [COUNT_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic [COUNT_W-1:0] mid_reg;
    logic [COUNT_W-1:0] mid;
    logic [COUNT_W-1:0] span;

    logic [ADDR_W-1:0]        quo_reg, quo_next;
    logic [WIDTH_W-1:0]       rem_reg, rem_next;
    logic [WIDTH_W-1:0]       divisor_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [WIDTH_W:0]         rem_shift;
    logic [WIDTH_W:0]         trial;

    logic                     mem_we;
    logic [SUM_W:0]           sum_ext;
    logic [PROD_W-1:0]        product;

    logic        found_reg;
    logic [15:0] index_out_reg;
    logic [11:0] x_out_reg;
    logic [15:0] y_out_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= wps_pkg::WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    // A load is dropped once the table is full.
    assign mem_we  = cmd.load && (count_reg < wps_pkg::COUNT_FULL);
    assign sum_ext = {1'b0, total_reg}
                   + (SUM_W + 1)'(s_weight[wps_pkg::WEIGHT_BITS-1:0]);

    // Entry count and saturating total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (cmd.restart) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (mem_we) begin
            count_reg <= count_reg + COUNT_W'(1);
            total_reg <= sum_ext[SUM_W] ? wps_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
        end
    end

    // Midpoint of the open search window.
    assign span = hi_reg - lo_reg;
    assign mid  = lo_reg + (span >> 1);
    assign status.search_more = (span > COUNT_W'(1));

    // Table port: at most one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cum_mem[count_reg[ADDR_W-1:0]] <= total_reg;
        end
        rd_data_reg <= cum_mem[mid[ADDR_W-1:0]];
    end

    // Scaled target: total times fraction, floored.
    assign product = PROD_W'(total_reg) * PROD_W'(s_fraction);

    // Search window update.
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.query_start) begin
            lo_next = '0;
            hi_next = count_reg;
        end else if (cmd.search_cmp) begin
            if (rd_data_reg <= scaled_reg) begin
                lo_next = mid_reg;
            end else begin
                hi_next = mid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.query_start) begin
            scaled_reg <= product[PROD_W-1:FRAC_W];
        end
        if (cmd.search_rd) begin
            mid_reg <= mid;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.div_init) begin
            quo_next = lo_reg[ADDR_W-1:0];
            rem_next = '0;
        end else if (cmd.div_step) begin
            if (!trial[WIDTH_W]) begin
                rem_next = trial[WIDTH_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[WIDTH_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.div_init) begin
            divisor_reg <= (width_reg == '0) ? WIDTH_W'(1) : width_reg;
            step_reg    <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign status.div_last = (step_reg == wps_pkg::LAST_STEP);

    // Result register. With a nonempty table and a nonzero total the
    // search always lands inside an interval; otherwise it is a miss.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (count_reg != '0 && total_reg != '0) begin
                found_reg     <= 1'b1;
                index_out_reg <= 16'(lo_reg);
                x_out_reg     <= 12'(rem_reg);
                y_out_reg     <= 16'(quo_reg);
            end else begin
                found_reg     <= 1'b0;
                index_out_reg <= '0;
                x_out_reg     <= '0;
                y_out_reg     <= '0;
            end
        end
    end

    assign m_found       = found_reg;
    assign m_entry_index = index_out_reg;
    assign m_pixel_x     = x_out_reg;
    assign m_pixel_y     = y_out_reg;

endmodule
